>>> rtl/cru_pkg.sv
// ----------------------------------------------------------------------------
// cru_pkg
// Shared widths, register map, decode phase codes and control structs for
// the channel RLE unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cru_pkg;

    // Field and register widths
    localparam int DIM_W       = 13;
    localparam int TOTAL_W     = 26;
    localparam int OFFSET_W    = 26;
    localparam int CNT_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int MAX_DIM_DEF = 4096;

    // Header byte split between repeat runs and literal runs
    localparam logic [BYTE_W-1:0] RLE_SPLIT = 8'd128;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_SLOT   = 2'd3;

    // Compression modes
    localparam logic MODE_RAW = 1'b0;
    localparam logic MODE_RLE = 1'b1;

    // Decode phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_REPEAT  = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

    // Configuration as seen by the decode core
    typedef struct packed {
        logic                mode;
        logic [DIM_W-1:0]    width;    // clamped pixels per row
        logic [SLOT_W-1:0]   slot;
        logic [TOTAL_W-1:0]  total;    // clamped width times clamped height
        logic                clear;    // register write, restart decode
    } cfg_t;

    // Decode core status
    typedef struct packed {
        logic at_start;
    } status_t;

endpackage : cru_pkg

`default_nettype wire

>>> rtl/cru_cfg.sv
// ----------------------------------------------------------------------------
// cru_cfg
// APB register file: mode, width, height and channel slot, with clamped
// dimensions and a registered pixel total for the decode core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cru_cfg #(
    parameter int MAX_DIM = cru_pkg::MAX_DIM_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cru_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cru_pkg::DATA_W-1:0]  pwdata,
    output logic      [cru_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output cru_pkg::cfg_t                    cfg
);
    import cru_pkg::*;

    logic                 mode_reg;
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [DIM_W-1:0]     width_c;
    logic [DIM_W-1:0]     height_c;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (32'(d) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RAW;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            slot_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_SLOT:   slot_reg   <= pwdata[SLOT_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // Clamp dimensions and register the pixel total
    assign width_c    = clamp_dim(width_reg);
    assign height_c   = clamp_dim(height_reg);
    assign total_next = TOTAL_W'(width_c) * TOTAL_W'(height_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= TOTAL_W'(1);
        else
            total_reg <= total_next;
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_MODE:   prdata = DATA_W'(mode_reg);
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_SLOT:   prdata = DATA_W'(slot_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.width = width_c;
    assign cfg.slot  = slot_reg;
    assign cfg.total = total_reg;
    assign cfg.clear = wr_en;

endmodule : cru_cfg

`default_nettype wire

>>> rtl/cru_core.sv
// ----------------------------------------------------------------------------
// cru_core
// Input byte register, raw/RLE decode state and fill-command result
// register. One byte is decoded per cycle while the result register is free or being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cru_core #(
    parameter int MAX_DIM = cru_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cru_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cru_pkg::BYTE_W-1:0]    stream_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [cru_pkg::BYTE_W-1:0]    fill_value,
    output logic      [cru_pkg::OFFSET_W-1:0]  start_offset,
    output logic      [cru_pkg::CNT_W-1:0]     fill_count,
    output logic                               channel_done,
    output cru_pkg::status_t                   status
);
    import cru_pkg::*;

    localparam int COL_W = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W;

    // Input stage
    logic                 in_vld_reg;
    logic [BYTE_W-1:0]    byte_reg;

    // Decode state
    phase_t               phase_reg,  phase_next;
    logic [CNT_W-1:0]     lit_reg,    lit_next;
    logic [TOTAL_W-1:0]   pix_reg,    pix_next;
    logic [COL_W-1:0]     col_reg,    col_next;
    logic [1:0]           pad_reg,    pad_next;

    // Result stage
    logic                 out_vld_reg;
    logic [BYTE_W-1:0]    value_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 done_reg;

    // Fill datapath
    logic                 go;
    logic                 emit;
    logic [CNT_W-1:0]     want;
    logic [TOTAL_W-1:0]   remaining;
    logic [CNT_W-1:0]     count;
    logic                 done;
    logic [COL_W:0]       col_inc;

    assign go       = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || go;

    // Hold one request byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_vld_reg <= 1'b1;
        else if (go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= stream_byte;
    end

    // Clip the fill at the last pixel
    always_comb
    begin
        remaining = (pix_reg < cfg.total) ? (cfg.total - pix_reg) : TOTAL_W'(1);
        count     = (TOTAL_W'(want) > remaining) ? remaining[CNT_W-1:0] : want;
        if (count == '0)
            count = CNT_W'(1);
        done      = (TOTAL_W'(count) == remaining);
    end

    // Decode one byte
    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        pix_next   = pix_reg;
        col_next   = col_reg;
        pad_next   = pad_reg;
        emit       = 1'b0;
        want       = CNT_W'(1);
        col_inc    = (COL_W+1)'(col_reg) + (COL_W+1)'(1);

        if (cfg.mode == MODE_RAW)
        begin
            if (pad_reg != '0)
                pad_next = pad_reg - 2'd1;
            else
            begin
                emit = 1'b1;
                if ((DIM_W+1)'(col_inc) >= (DIM_W+1)'(cfg.width))
                begin
                    col_next = '0;
                    pad_next = 2'(3'd4 - {1'b0, cfg.width[1:0]});
                end
                else
                    col_next = col_inc[COL_W-1:0];
            end
        end
        else
        begin
            case (phase_reg)
                PH_REPEAT:
                begin
                    emit       = 1'b1;
                    want       = lit_reg;
                    phase_next = PH_HEADER;
                    lit_next   = '0;
                end
                PH_LITERAL:
                begin
                    emit = 1'b1;
                    if (lit_reg != '0)
                        lit_next = lit_reg - CNT_W'(1);
                    if (lit_next == '0)
                        phase_next = PH_HEADER;
                end
                default:
                begin
                    if (byte_reg > RLE_SPLIT)
                    begin
                        lit_next   = byte_reg - RLE_SPLIT;
                        phase_next = PH_REPEAT;
                    end
                    else if (byte_reg != '0)
                    begin
                        lit_next   = byte_reg;
                        phase_next = PH_LITERAL;
                    end
                    else
                        phase_next = PH_HEADER;
                end
            endcase
        end

        // Advance or restart after the fill
        if (emit)
        begin
            if (done)
            begin
                phase_next = PH_HEADER;
                lit_next   = '0;
                pix_next   = '0;
                col_next   = '0;
                pad_next   = '0;
            end
            else
                pix_next = pix_reg + TOTAL_W'(count);
        end
    end

    // Update decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= '0;
            pix_reg   <= '0;
            col_reg   <= '0;
            pad_reg   <= '0;
        end
        else if (cfg.clear)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= '0;
            pix_reg   <= '0;
            col_reg   <= '0;
            pad_reg   <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            pix_reg   <= pix_next;
            col_reg   <= col_next;
            pad_reg   <= pad_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (go && emit)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            value_reg  <= byte_reg;
            offset_reg <= {pix_reg[OFFSET_W-SLOT_W-1:0], cfg.slot};
            count_reg  <= count;
            done_reg   <= done;
        end
    end

    assign out_valid    = out_vld_reg;
    assign fill_value   = value_reg;
    assign start_offset = offset_reg;
    assign fill_count   = count_reg;
    assign channel_done = done_reg;

    assign status.at_start = (phase_reg == PH_HEADER) && (lit_reg == '0) &&
                             (pix_reg == '0) && (col_reg == '0) && (pad_reg == '0);

endmodule : cru_core

`default_nettype wire

>>> rtl/channel_rle_unpacker.sv
// ----------------------------------------------------------------------------
// channel_rle_unpacker
// Decodes one image channel, raw with row padding or run-length coded, from
// a byte stream into fill commands for a four-byte-per-pixel frame.
//
// Usage:
//   Program mode, width, height and channel slot over the APB port while
//   the block is idle; any write restarts decoding at pixel zero.
//   Stream bytes enter on in_valid/in_ready, one request per byte. Each
//   byte yields at most one fill command on out_valid/out_ready.
//   A fill's byte lands in the input register first, then the result
//   register loads the fill once that register is free or being taken.
//   Throughput: one byte per cycle while the receiver takes each fill.
//   A new byte is taken while a finished fill waits; when the receiver
//   stalls, the result and input registers fill and in_ready drops.
//   Reset: registers go to raw mode, 1x1 image, slot 0; decode restarts.
//   After the fill that reaches the last pixel, decoding returns to its
//   start state, so row pad bytes after the last raw row are taken as
//   data of the next pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module channel_rle_unpacker #(
    parameter int MAX_DIM = cru_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cru_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [cru_pkg::DATA_W-1:0]    pwdata,
    output logic      [cru_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cru_pkg::BYTE_W-1:0]    stream_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [cru_pkg::BYTE_W-1:0]    fill_value,
    output logic      [cru_pkg::OFFSET_W-1:0]  start_offset,
    output logic      [cru_pkg::CNT_W-1:0]     fill_count,
    output logic                               channel_done
);
    import cru_pkg::*;

    cfg_t    cfg;
    status_t status;

    cru_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cru_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fill_value   (fill_value),
        .start_offset (start_offset),
        .fill_count   (fill_count),
        .channel_done (channel_done),
        .status       (status)
    );

    // A fill always covers one to 127 pixels, within the checked bound of 128
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_count != '0) && (fill_count <= CNT_W'(128)))
        else $error("fill count out of range");

    // Offsets land on the configured channel byte
    a_offset_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_offset[SLOT_W-1:0] == cfg.slot))
        else $error("start offset not on channel slot");

    // A register write restarts decoding
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> status.at_start)
        else $error("decode state not restarted after register write");

endmodule : channel_rle_unpacker

`default_nettype wire
